// ----- sv/fat32ate_pkg.sv -----
// ----------------------------------------------------------------------------
// fat32ate_pkg
// Shared types and constants of the FAT32 allocation table engine.
// ----------------------------------------------------------------------------
package fat32ate_pkg;

  localparam int KIND_W     = 2;
  localparam int CLUSTER_W  = 12;
  localparam int ENTRY_W    = 28;
  localparam int STATUS_W   = 2;
  localparam int SECTORS_W  = 6;
  localparam int ENTRY_SHIFT = 7;
  localparam int USED_W     = SECTORS_W + ENTRY_SHIFT;
  localparam int IN_DATA_W  = CLUSTER_W + ENTRY_W;
  localparam int OUT_DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [SECTORS_W-1:0] FAT_SECTORS_RESET = 6'd32;
  localparam logic [USED_W-1:0]    FIRST_DATA_CLUSTER = 13'd2;

  typedef struct packed {
    logic accept;
    logic clear;
    logic scan;
    logic load_resp;
    logic load_scan;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_find;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/fat32ate_ram.sv -----
// ----------------------------------------------------------------------------
// fat32ate_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fat32ate_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- sv/fat32ate_ctrl.sv -----
// ----------------------------------------------------------------------------
// fat32ate_ctrl
// Controller: clearing pass, request accept, response and scan sequencing.
// ----------------------------------------------------------------------------
module fat32ate_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  fat32ate_pkg::sts_t  sts,
  output fat32ate_pkg::cmd_t  cmd
);

  import fat32ate_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RESP  = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = sts.in_find ? S_SCAN : S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_resp = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!sts.scan_done) begin
          cmd.scan = 1'b1;
        end else if (sts.out_free) begin
          cmd.load_scan = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/fat32ate_dp.sv -----
// ----------------------------------------------------------------------------
// fat32ate_dp
// Datapath: table memory, sector register, request registers, scan
// counters and the output register.
// ----------------------------------------------------------------------------
module fat32ate_dp #(
  parameter int MAX_SECTORS = 32
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic [fat32ate_pkg::IN_DATA_W-1:0]          s_tdata,
  input  logic [fat32ate_pkg::KIND_W-1:0]             s_tuser,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  output logic [fat32ate_pkg::OUT_DATA_W-1:0]         m_tdata,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [fat32ate_pkg::SECTORS_W-1:0]          cfg_data,
  input  fat32ate_pkg::cmd_t                          cmd,
  output fat32ate_pkg::sts_t                          sts
);

  import fat32ate_pkg::*;

  localparam int DEPTH  = MAX_SECTORS * 128;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [SECTORS_W-1:0] fat_sectors;
  logic [SECTORS_W-1:0] sectors_sat;
  logic [USED_W-1:0]    limit;

  logic [CLUSTER_W-1:0] in_cluster;
  logic [ENTRY_W-1:0]   in_value;
  logic                 in_range;

  logic [KIND_W-1:0]    kind_q;
  logic                 range_q;

  logic [ADDR_W-1:0]    clr_addr;
  logic [USED_W-1:0]    scan_addr;
  logic [USED_W-1:0]    chk_addr;
  logic                 chk_valid;
  logic                 hit;
  logic                 more;

  logic [ADDR_W-1:0]    ram_addr;
  logic                 ram_we;
  logic                 ram_re;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [ENTRY_W-1:0]   res_value;
  logic [STATUS_W-1:0]  res_status;
  logic [ENTRY_W-1:0]   resp_value;
  logic [STATUS_W-1:0]  resp_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fat_sectors <= FAT_SECTORS_RESET;
    end else if (cfg_valid) begin
      fat_sectors <= cfg_data;
    end
  end

  assign sectors_sat = (32'(fat_sectors) > MAX_SECTORS) ? SECTORS_W'(MAX_SECTORS)
                                                         : fat_sectors;
  assign limit       = {sectors_sat, {ENTRY_SHIFT{1'b0}}};

  assign in_cluster = s_tdata[CLUSTER_W-1:0];
  assign in_value   = s_tdata[IN_DATA_W-1:CLUSTER_W];
  assign in_range   = ({1'b0, in_cluster} < limit);

  assign hit  = chk_valid && (ram_rdata == '0);
  assign more = (scan_addr < limit);

  always_comb begin
    ram_addr  = ADDR_W'(scan_addr);
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = in_value;
    if (cmd.clear) begin
      ram_addr  = clr_addr;
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else if (cmd.accept) begin
      ram_addr = ADDR_W'(in_cluster);
      ram_we   = in_range && (s_tuser == KIND_WRITE);
      ram_re   = in_range && (s_tuser == KIND_READ);
    end else if (cmd.scan) begin
      ram_re = 1'b1;
    end
  end

  fat32ate_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .re    (ram_re),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q  <= s_tuser;
      range_q <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (cmd.accept) begin
      chk_valid <= 1'b0;
    end else if (cmd.scan) begin
      chk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_addr <= FIRST_DATA_CLUSTER;
    end else if (cmd.scan) begin
      chk_addr  <= scan_addr;
      scan_addr <= scan_addr + 1'b1;
    end
  end

  always_comb begin
    resp_value  = '0;
    resp_status = ST_OK;
    case (kind_q)
      KIND_READ: begin
        resp_value  = range_q ? ram_rdata : '0;
        resp_status = range_q ? ST_OK : ST_RANGE;
      end
      KIND_WRITE: begin
        resp_status = range_q ? ST_OK : ST_RANGE;
      end
      default: begin
        resp_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_resp || cmd.load_scan) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_resp) begin
      res_value  <= resp_value;
      res_status <= resp_status;
    end else if (cmd.load_scan) begin
      res_value  <= hit ? ENTRY_W'(chk_addr) : '0;
      res_status <= hit ? ST_OK : ST_FULL;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - ENTRY_W - STATUS_W){1'b0}}, res_status, res_value};

  assign sts.clear_last = (clr_addr == ADDR_W'(DEPTH - 1));
  assign sts.in_find    = (s_tuser == KIND_FIND);
  assign sts.scan_done  = hit || !more;
  assign sts.out_free   = !m_tvalid || m_tready;

endmodule

// ----- sv/fat32_allocation_table_engine_top.sv -----
// ----------------------------------------------------------------------------
// fat32_allocation_table_engine_top
// FAT32 allocation table held in internal memory: entry read, entry write
// and first-free-cluster scan.
//
//   Channel  Handshake          Payload
//   s        s_tvalid/s_tready  s_tdata: cluster, value; s_tuser: kind
//   m        m_tvalid/m_tready  m_tdata: result_value, status
//   cfg      cfg_valid/cfg_ready cfg_data: fat_sectors
//
// Read, write and unused kinds are accepted together with the table access;
// the response then goes into the output register.
// A scan reads one entry per cycle through the single table port.
// After reset a clearing pass zeroes all MAX_SECTORS * 128 entries of the
// table (4096 by default); s_tready stays low throughout.
// A held result in the output register stalls only the next response.
// ----------------------------------------------------------------------------
module fat32_allocation_table_engine_top #(
  parameter int MAX_SECTORS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // cluster[11:0], value[39:12]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_value[27:0], status[29:28], zero[31:30]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  import fat32ate_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fat32ate_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fat32ate_dp #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- tb/tb_fat32_allocation_table_engine_top.sv -----
// ----------------------------------------------------------------------------
// tb_fat32_allocation_table_engine_top
// Self-checking bench for the FAT32 allocation table engine. A shadow copy
// of the table and the sector count predicts every response to a read,
// write or free-cluster scan. Directed requests cover the table edges,
// reserved clusters, unused kind, zero and saturated sector counts. Random
// phases with varied sector counts follow, including a completely filled
// table. Both stream sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb_fat32_allocation_table_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fat32ate_pkg::*;

  localparam int TABLE_SECTORS = 32;
  localparam int SECTOR_ENTRIES = 128;
  localparam int TABLE_DEPTH = TABLE_SECTORS * SECTOR_ENTRIES;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam logic [ENTRY_W-1:0] ENTRY_MAX = 28'hFFFFFFF;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam int PHASE_ITEMS = 55;

  typedef struct packed {
    logic [ENTRY_W-1:0]  result_value;
    logic [STATUS_W-1:0] status;
  } reply_t;

  class fat_shadow;
    logic [ENTRY_W-1:0] entries [TABLE_DEPTH];
    int unsigned sectors;
    reply_t expected_replies[$];
    int unsigned mismatches;

    function new();
      foreach (entries[i]) entries[i] = '0;
      sectors = FAT_SECTORS_RESET;
      mismatches = 0;
    endfunction

    function void set_sectors(logic [SECTORS_W-1:0] count);
      sectors = count;
    endfunction

    function int unsigned entries_in_use();
      return ((sectors > TABLE_SECTORS) ? TABLE_SECTORS : sectors) * SECTOR_ENTRIES;
    endfunction

    function void apply_request(logic [KIND_W-1:0] kind, logic [CLUSTER_W-1:0] cluster,
                                logic [ENTRY_W-1:0] value);
      reply_t want;
      int unsigned used;
      bit found;
      used = entries_in_use();
      want.result_value = '0;
      want.status = ST_OK;
      found = 0;
      case (kind)
        KIND_READ: begin
          if (cluster < used) want.result_value = entries[cluster];
          else want.status = ST_RANGE;
        end
        KIND_WRITE: begin
          if (cluster < used) entries[cluster] = value;
          else want.status = ST_RANGE;
        end
        KIND_FIND: begin
          for (int c = FIRST_DATA_CLUSTER; c < used && !found; c++) begin
            if (entries[c] == '0) begin
              want.result_value = ENTRY_W'(c);
              found = 1;
            end
          end
          if (!found) want.status = ST_FULL;
        end
        default: begin
        end
      endcase
      expected_replies.push_back(want);
    endfunction

    function void match_reply(logic [OUT_DATA_W-1:0] data);
      reply_t want;
      logic [ENTRY_W-1:0] got_value;
      logic [STATUS_W-1:0] got_status;
      got_value = data[ENTRY_W-1:0];
      got_status = data[ENTRY_W +: STATUS_W];
      if (expected_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, actual value %h status %0d",
                 $time, got_value, got_status);
        return;
      end
      want = expected_replies.pop_front();
      if (got_value !== want.result_value) begin
        mismatches++;
        $display("%0t: result_value mismatch, expected %h actual %h",
                 $time, want.result_value, got_value);
      end
      if (got_status !== want.status) begin
        mismatches++;
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, got_status);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [SECTORS_W-1:0]  cfg_data = '0;

  fat_shadow shadow = new();
  bit        settle = 0;
  longint    cycle_count = 0;

  always #5 clk = ~clk;

  fat32_allocation_table_engine_top #(
    .MAX_SECTORS(TABLE_SECTORS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) shadow.match_reply(m_tdata);
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    wait (!rst);
    forever begin
      if (settle) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [CLUSTER_W-1:0] cluster,
                              input logic [ENTRY_W-1:0] value);
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {value, cluster};
    do @(posedge clk); while (!s_tready);
    shadow.apply_request(kind, cluster, value);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (shadow.expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [SECTORS_W-1:0] sectors);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= sectors;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow.set_sectors(sectors);
  endtask

  task automatic random_request();
    int unsigned pick;
    int unsigned used;
    int unsigned window;
    logic [KIND_W-1:0] kind;
    logic [CLUSTER_W-1:0] cluster;
    logic [ENTRY_W-1:0] value;
    used = shadow.entries_in_use();
    window = (used == 0) ? 64 : ((used < 64) ? used : 64);
    pick = $urandom_range(0, 99);
    kind = (pick < 36) ? KIND_READ : (pick < 74) ? KIND_WRITE :
           (pick < 95) ? KIND_FIND : KIND_NONE;
    pick = $urandom_range(0, 99);
    if (pick < 65) cluster = CLUSTER_W'($urandom_range(0, window - 1));
    else if (pick < 85 && used != 0) cluster = CLUSTER_W'($urandom_range(0, used - 1));
    else cluster = CLUSTER_W'($urandom_range(0, TABLE_DEPTH - 1));
    pick = $urandom_range(0, 99);
    if (pick < 25) value = '0;
    else if (pick < 45) value = ENTRY_W'($urandom_range(1, 4095));
    else if (pick < 55) value = ENTRY_W'($urandom_range(28'hFFFFFF8, ENTRY_MAX));
    else value = ENTRY_W'($urandom_range(0, ENTRY_MAX));
    if (!settle && $urandom_range(0, 59) == 0) drain();
    else if (!settle && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 19));
    send_request(kind, cluster, value);
  endtask

  task automatic random_phase(input logic [SECTORS_W-1:0] sectors, input int unsigned count);
    reconfigure(sectors);
    repeat (count) random_request();
  endtask

  task automatic fill_phase();
    int unsigned hole;
    reconfigure(6'd1);
    for (int c = FIRST_DATA_CLUSTER; c < SECTOR_ENTRIES; c++) begin
      if (!settle && $urandom_range(0, 9) == 0) pause_sender($urandom_range(1, 19));
      send_request(KIND_WRITE, CLUSTER_W'(c), ENTRY_W'($urandom_range(1, ENTRY_MAX)));
    end
    send_request(KIND_FIND, '0, '0);
    hole = $urandom_range(FIRST_DATA_CLUSTER, SECTOR_ENTRIES - 1);
    send_request(KIND_WRITE, CLUSTER_W'(hole), '0);
    send_request(KIND_FIND, '0, '0);
    repeat (30) random_request();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_request(KIND_FIND, '0, '0);
    send_request(KIND_READ, 12'd0, '0);
    send_request(KIND_WRITE, 12'd0, ENTRY_MAX);
    send_request(KIND_WRITE, 12'd1, ENTRY_MAX);
    send_request(KIND_READ, 12'd1, '0);
    send_request(KIND_FIND, '0, ENTRY_MAX);
    send_request(KIND_WRITE, 12'd2, 28'd1);
    send_request(KIND_WRITE, 12'd3, 28'hFFFFFF8);
    send_request(KIND_FIND, '0, '0);
    send_request(KIND_WRITE, 12'd4095, 28'hABCDEF0);
    send_request(KIND_READ, 12'd4095, '0);
    send_request(KIND_NONE, 12'd4095, ENTRY_MAX);
    send_request(KIND_WRITE, 12'd4095, '0);
    send_request(KIND_READ, 12'd4095, '0);

    reconfigure(6'd0);
    send_request(KIND_READ, 12'd0, '0);
    send_request(KIND_WRITE, 12'd5, ENTRY_MAX);
    send_request(KIND_FIND, '0, '0);

    reconfigure(6'd63);
    send_request(KIND_READ, 12'd4095, '0);
    send_request(KIND_WRITE, 12'd4095, 28'h5555555);
    send_request(KIND_READ, 12'd4095, '0);
    send_request(KIND_FIND, '0, '0);

    reconfigure(6'd1);
    send_request(KIND_READ, 12'd128, '0);
    send_request(KIND_WRITE, 12'd127, 28'hAAAAAAA);
    send_request(KIND_READ, 12'd127, '0);
    send_request(KIND_WRITE, 12'd128, 28'd1);
    send_request(KIND_FIND, '0, '0);

    random_phase(6'd2, PHASE_ITEMS);
    fill_phase();
    random_phase(6'd32, PHASE_ITEMS);
    random_phase(SECTORS_W'($urandom_range(3, 31)), PHASE_ITEMS);
    random_phase(SECTORS_W'($urandom_range(33, 62)), PHASE_ITEMS);
    random_phase(6'd0, 20);
    settle = 1;
    random_phase(6'd32, PHASE_ITEMS);

    s_tvalid <= 1'b0;
    while (shadow.expected_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.expected_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- fat32_allocation_table_engine_top.f -----
sv/fat32ate_pkg.sv
sv/fat32ate_ram.sv
sv/fat32ate_ctrl.sv
sv/fat32ate_dp.sv
sv/fat32_allocation_table_engine_top.sv
tb/tb_fat32_allocation_table_engine_top.sv
